@@ sv/pwm_tone_divider_solver_assert.svh @@
// Assertion macros used by the tone divider solver top level.
`ifndef PWM_TONE_DIVIDER_SOLVER_ASSERT_SVH
`define PWM_TONE_DIVIDER_SOLVER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define PTD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define PTD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/ptd_pkg.sv @@
// Package: widths, codes, constants and control types of the tone divider solver.
package ptd_pkg;

  localparam int CLK_W       = 28;
  localparam int TONE_W      = 16;
  localparam int DIV_W       = 12;
  localparam int WRAP_W      = 16;
  localparam int LVL_W       = 15;
  localparam int ST_W        = 2;
  localparam int Q_W         = 32;
  localparam int CNT_W       = 5;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_W       = 28;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 64;
  localparam int OUT_USED_W  = DIV_W + WRAP_W + LVL_W + TONE_W;

  localparam int unsigned WRAP_LIMIT_DEF = 65534;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_CLK  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_TONE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TONE = 2'd2;

  localparam logic [CLK_W-1:0]  SRC_CLK_RST  = 28'd125000000;
  localparam logic [TONE_W-1:0] MIN_TONE_RST = 16'd20;
  localparam logic [TONE_W-1:0] MAX_TONE_RST = 16'd20000;

  localparam logic [DIV_W-1:0]  DIV_RST  = 12'd16;
  localparam logic [WRAP_W-1:0] WRAP_RST = 16'hFFFF;
  localparam logic [LVL_W-1:0]  HALF_LEVEL = 15'h7FFF;

  // status codes
  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_HIGH = 2'd1;
  localparam logic [ST_W-1:0] ST_LOW  = 2'd2;

  // modular inverses mod 2^32 and exact-divisibility bounds
  localparam logic [Q_W-1:0] INV5 = 32'hCCCCCCCD;
  localparam logic [Q_W-1:0] MAX5 = 32'h33333333;
  localparam logic [Q_W-1:0] INV3 = 32'hAAAAAAAB;
  localparam logic [Q_W-1:0] MAX3 = 32'h55555555;

  typedef struct packed {
    logic load;
    logic div_step;
    logic mul_en;
    logic mul_sel3;
    logic apply_q;
    logic apply2;
    logic finish;
  } ptd_cmd_t;

  typedef struct packed {
    logic fac_ok;
    logic two_ok;
    logic out_block;
  } ptd_sts_t;

endpackage

@@ sv/pwm_tone_divider_solver.sv @@
// Sequence: after the input beat, 32 divide steps, up to 15 factor moves, a final check
//   of the factors and a commit into the result register.
// Throughput: one command at a time; the next beat is taken the cycle after the commit,
//   and the commit waits while an earlier result waits on m_axis_tready.
// Reset (async, active low): config returns to 125 MHz / 20 Hz / 20000 Hz,
//   divider 16, wrap 65535, level 0, tone 0, no result pending.
`include "pwm_tone_divider_solver_assert.svh"

module pwm_tone_divider_solver #(
  parameter int unsigned WRAP_LIMIT = ptd_pkg::WRAP_LIMIT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [ptd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [ptd_pkg::CFG_W-1:0]       cfg_wdata_i,
  // command stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [ptd_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // [15:0] tone_hz
  input  logic                            s_axis_tuser,  // [0] cmd (1 = mute)
  // result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [ptd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // [11:0] clock_divider,
                                                         // [27:12] wrap_value,
                                                         // [42:28] duty_level,
                                                         // [58:43] current_tone_hz
  output logic [ptd_pkg::ST_W-1:0]        m_axis_tuser   // [1:0] status
);
  import ptd_pkg::*;

  ptd_cmd_t          cmd;
  ptd_sts_t          sts;
  logic [DIV_W-1:0]  out_div;
  logic [WRAP_W-1:0] out_wrap;
  logic [LVL_W-1:0]  out_level;
  logic [TONE_W-1:0] out_tone;

  // FSM: accepts a beat only when idle; the result register parts the output side
  ptd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // divider, factoring and the programmed PWM registers
  ptd_datapath #(
    .WRAP_LIMIT (WRAP_LIMIT)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_mute_i    (s_axis_tuser),
    .in_tone_i    (s_axis_tdata),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_div_o    (out_div),
    .out_wrap_o   (out_wrap),
    .out_level_o  (out_level),
    .out_status_o (m_axis_tuser),
    .out_tone_o   (out_tone)
  );

  assign m_axis_tdata = {{(OUT_TDATA_W-OUT_USED_W){1'b0}},
                         out_tone, out_level, out_wrap, out_div};

  // programmed divider never leaves the legal 8.4 range
  `PTD_ASSERT_IMPL(a_div_range, clk_i, rst_ni, m_axis_tvalid,
                   out_div >= DIV_W'(16), "clock divider below 16")
  // once a command is taken, no second one until it finishes
  `PTD_ASSERT_NEXT(a_one_at_a_time, clk_i, rst_ni, s_axis_tvalid && s_axis_tready,
                   !s_axis_tready, "input accepted while busy")
  // duty level is either off or half scale
  `PTD_ASSERT_IMPL(a_level_code, clk_i, rst_ni, m_axis_tvalid,
                   (out_level == '0) || (out_level == HALF_LEVEL), "bad duty level")

endmodule

@@ sv/ptd_ctrl.sv @@
// Controller: sequences the serial divide, the factoring loop and the commit.
module ptd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ptd_pkg::ptd_sts_t sts_i,
  output ptd_pkg::ptd_cmd_t cmd_o
);
  import ptd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_MUL5, S_CHK5, S_MUL3, S_CHK3, S_CHK2, S_FIN
  } state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        cmd_o.load = in_valid_i;
        cnt_d      = '0;
        if (in_valid_i) state_d = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (&cnt_q) state_d = S_MUL5;
      end
      S_MUL5: begin
        cmd_o.mul_en = 1'b1;
        state_d      = S_CHK5;
      end
      S_CHK5: begin
        if (sts_i.fac_ok) begin
          cmd_o.apply_q = 1'b1;
          state_d       = S_MUL5;
        end else begin
          state_d = S_MUL3;
        end
      end
      S_MUL3: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_sel3 = 1'b1;
        state_d        = S_CHK3;
      end
      S_CHK3: begin
        if (sts_i.fac_ok) begin
          cmd_o.apply_q = 1'b1;
          state_d       = S_MUL5;
        end else begin
          state_d = S_CHK2;
        end
      end
      S_CHK2: begin
        if (sts_i.two_ok) begin
          cmd_o.apply2 = 1'b1;
          state_d      = S_MUL5;
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!sts_i.out_block) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

@@ sv/ptd_datapath.sv @@
// Datapath: config registers, restoring divider, factor unit and PWM state.
module ptd_datapath #(
  parameter int unsigned WRAP_LIMIT = ptd_pkg::WRAP_LIMIT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ptd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ptd_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                          in_mute_i,
  input  logic [ptd_pkg::TONE_W-1:0]    in_tone_i,
  input  ptd_pkg::ptd_cmd_t             cmd_i,
  output ptd_pkg::ptd_sts_t             sts_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [ptd_pkg::DIV_W-1:0]     out_div_o,
  output logic [ptd_pkg::WRAP_W-1:0]    out_wrap_o,
  output logic [ptd_pkg::LVL_W-1:0]     out_level_o,
  output logic [ptd_pkg::ST_W-1:0]      out_status_o,
  output logic [ptd_pkg::TONE_W-1:0]    out_tone_o
);
  import ptd_pkg::*;

  localparam logic [WRAP_W+2:0] LIM = (WRAP_W+3)'(WRAP_LIMIT);

  logic [CLK_W-1:0]  src_clk_q;
  logic [TONE_W-1:0] min_q, max_q;
  logic              mute_q, use_clk_q, sel3_q;
  logic [CLK_W-1:0]  desired_q, rem_q;
  logic [Q_W-1:0]    d_q, q_q;
  logic [WRAP_W-1:0] p_q;
  logic [DIV_W-1:0]  div_q;
  logic [WRAP_W-1:0] wrap_q;
  logic [LVL_W-1:0]  level_q;
  logic [TONE_W-1:0] tone_q;
  logic [ST_W-1:0]   status_q;
  logic              out_valid_q;

  // input clamp and frequency select
  logic [TONE_W-1:0] clamp_hi, clamp;
  logic              use_clk;
  logic [CLK_W-1:0]  des_raw, des_d;

  assign clamp_hi = (in_tone_i < max_q) ? in_tone_i : max_q;
  assign clamp    = (clamp_hi < min_q) ? min_q : clamp_hi;
  assign use_clk  = in_mute_i || (in_tone_i == '0);
  assign des_raw  = use_clk ? src_clk_q : {{(CLK_W-TONE_W){1'b0}}, clamp};
  assign des_d    = (des_raw == '0) ? CLK_W'(1) : des_raw;

  // one restoring divide step per cycle, quotient shifts into d_q
  logic [CLK_W:0] trial, diff;
  logic           ge;
  assign trial = {rem_q, d_q[Q_W-1]};
  assign ge    = (trial >= {1'b0, desired_q});
  assign diff  = trial - {1'b0, desired_q};

  // exact division by 5 or 3 through the inverse mod 2^32
  logic [Q_W-1:0] q_mul;
  assign q_mul = d_q * (cmd_i.mul_sel3 ? INV3 : INV5);

  logic [WRAP_W+2:0] p5, p3, p2;
  assign p5 = {3'b000, p_q} + {1'b0, p_q, 2'b00};
  assign p3 = {3'b000, p_q} + {2'b00, p_q, 1'b0};
  assign p2 = {2'b00, p_q, 1'b0};

  assign sts_o.fac_ok = sel3_q ? ((d_q >= Q_W'(48)) && (q_q <= MAX3) && (p3 <= LIM))
                               : ((d_q >= Q_W'(80)) && (q_q <= MAX5) && (p5 <= LIM));
  assign sts_o.two_ok    = (d_q >= Q_W'(32)) && (p2 <= LIM);
  assign sts_o.out_block = out_valid_q && !out_ready_i;

  logic [ST_W-1:0] st;
  always_comb begin
    if (d_q < Q_W'(16))           st = ST_HIGH;
    else if (|d_q[Q_W-1:DIV_W])   st = ST_LOW;
    else                          st = ST_OK;
  end

  // config and PWM state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_clk_q   <= SRC_CLK_RST;
      min_q       <= MIN_TONE_RST;
      max_q       <= MAX_TONE_RST;
      div_q       <= DIV_RST;
      wrap_q      <= WRAP_RST;
      level_q     <= '0;
      tone_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SRC_CLK:  src_clk_q <= cfg_wdata_i[CLK_W-1:0];
          CFG_MIN_TONE: min_q     <= cfg_wdata_i[TONE_W-1:0];
          CFG_MAX_TONE: max_q     <= cfg_wdata_i[TONE_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.finish) begin
        level_q     <= mute_q ? '0 : HALF_LEVEL;
        out_valid_q <= 1'b1;
        if (st == ST_OK) begin
          div_q  <= d_q[DIV_W-1:0];
          wrap_q <= p_q - 1'b1;
          tone_q <= use_clk_q ? '0 : desired_q[TONE_W-1:0];
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mute_q    <= in_mute_i;
      use_clk_q <= use_clk;
      desired_q <= des_d;
      rem_q     <= '0;
      d_q       <= {src_clk_q, 4'b0000};
      p_q       <= WRAP_W'(1);
    end
    if (cmd_i.div_step) begin
      rem_q <= ge ? diff[CLK_W-1:0] : trial[CLK_W-1:0];
      d_q   <= {d_q[Q_W-2:0], ge};
    end
    if (cmd_i.mul_en) begin
      q_q    <= q_mul;
      sel3_q <= cmd_i.mul_sel3;
    end
    if (cmd_i.apply_q) begin
      d_q <= q_q;
      p_q <= sel3_q ? p3[WRAP_W-1:0] : p5[WRAP_W-1:0];
    end
    if (cmd_i.apply2) begin
      d_q <= {1'b0, d_q[Q_W-1:1]};
      p_q <= p2[WRAP_W-1:0];
    end
    if (cmd_i.finish) status_q <= st;
  end

  assign out_valid_o  = out_valid_q;
  assign out_div_o    = div_q;
  assign out_wrap_o   = wrap_q;
  assign out_level_o  = level_q;
  assign out_status_o = status_q;
  assign out_tone_o   = tone_q;

endmodule

@@ test/tb.sv @@
// Self-checking testbench for the PWM tone divider solver: directed and random commands.
module tb;
  import ptd_pkg::*;

  // Cycles with no beat on either side before the run is called hung. The
  // slowest legal gap is the long receiver hold-off plus one solve; this is
  // several times that.
  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;
  // Cycles to let pass after the last result before the verdict.
  localparam int DRAIN_CYCLES = 150;
  localparam int MAX_PRINTS = 200;

  // Legal 8.4 divider window.
  localparam longint unsigned DIV_FLOOR = 16;
  localparam longint unsigned DIV_CEIL = 4096;

  localparam int LVL_LSB = DIV_W + WRAP_W;
  localparam int TONE_LSB = DIV_W + WRAP_W + LVL_W;

  // One programmed tone setup, as the block reports it.
  typedef struct {
    logic [DIV_W-1:0]  divider;
    logic [WRAP_W-1:0] wrap;
    logic [LVL_W-1:0]  level;
    logic [ST_W-1:0]   status;
    logic [TONE_W-1:0] tone;
  } tone_setup_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i = '0;
  logic [CFG_W-1:0]       cfg_wdata_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;  // [15:0] tone_hz
  logic                   s_axis_tuser = 1'b0;  // [0] cmd (1 = mute)
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;  // [11:0] divider, [27:12] wrap,
                                         // [42:28] level, [58:43] tone
  logic [ST_W-1:0]        m_axis_tuser;  // [1:0] status

  pwm_tone_divider_solver uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Shadow copy of the configuration and the programmed slice.
  logic [CLK_W-1:0]  src_hz_cfg = SRC_CLK_RST;
  logic [TONE_W-1:0] min_tone_cfg = MIN_TONE_RST;
  logic [TONE_W-1:0] max_tone_cfg = MAX_TONE_RST;
  logic [DIV_W-1:0]  div_now = DIV_RST;
  logic [WRAP_W-1:0] wrap_now = WRAP_RST;
  logic [LVL_W-1:0]  level_now = '0;
  logic [TONE_W-1:0] tone_now = '0;

  tone_setup_t setups_due[$];
  tone_setup_t due;
  int          mismatches = 0;
  int          stall_cycles = 0;

  // Idle control shared by both sides; hold_tok asks the receiver for a long hold.
  bit steady = 1'b0;
  int hold_tok = 0;
  int hold_seen = 0;
  int hold_left = 0;

  // Solve one command against the shadow state and update it.
  function automatic tone_setup_t solve_tone(input logic mute, input logic [TONE_W-1:0] tone_hz);
    tone_setup_t     r;
    logic            use_src;
    longint unsigned want;
    longint unsigned d;
    longint unsigned p;
    longint unsigned lim;
    bit              busy;
    use_src = mute || (tone_hz == '0);
    if (use_src) begin
      want = src_hz_cfg;
    end else begin
      want = (tone_hz < max_tone_cfg) ? tone_hz : max_tone_cfg;
      if (want < min_tone_cfg) begin
        want = min_tone_cfg;
      end
    end
    // zero frequency would divide by zero
    if (want == 0) begin
      want = 1;
    end
    d = (longint'(src_hz_cfg) * 16) / want;
    p = 1;
    lim = WRAP_LIMIT_DEF;
    busy = 1'b1;
    // pull factors 5, 3, 2 into the wrap count, in that order of preference
    while (busy) begin
      if (d >= 80 && d % 5 == 0 && p * 5 <= lim) begin
        d = d / 5;
        p = p * 5;
      end else if (d >= 48 && d % 3 == 0 && p * 3 <= lim) begin
        d = d / 3;
        p = p * 3;
      end else if (d >= 32 && p * 2 <= lim) begin
        d = d / 2;
        p = p * 2;
      end else begin
        busy = 1'b0;
      end
    end
    if (d < DIV_FLOOR) begin
      r.status = ST_HIGH;
    end else if (d >= DIV_CEIL) begin
      r.status = ST_LOW;
    end else begin
      r.status = ST_OK;
      div_now  = DIV_W'(d);
      wrap_now = WRAP_W'(p - 1);
      tone_now = use_src ? '0 : TONE_W'(want);
    end
    // level follows the command even on error
    level_now = mute ? '0 : HALF_LEVEL;
    r.divider = div_now;
    r.wrap    = wrap_now;
    r.level   = level_now;
    r.tone    = tone_now;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    // keep the log bounded on a badly broken build
    if (mismatches < MAX_PRINTS) begin
      $display("MISMATCH %s: got %0d, want %0d", what, got, want);
    end
    mismatches++;
  endtask

  // Send one command beat; the expectation is queued at the accepting edge.
  // Handshakes are read at the falling edge, where every signal is settled.
  task automatic send_cmd(input logic mute, input logic [TONE_W-1:0] tone_hz);
    bit taken;
    while (!steady && $urandom_range(99) < 7) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= tone_hz;
    s_axis_tuser  <= mute;
    do begin
      @(negedge clk_i);
      taken = s_axis_tready;
      @(posedge clk_i);
    end while (!taken);
    setups_due.push_back(solve_tone(mute, tone_hz));
  endtask

  task automatic end_burst();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Every command yields a result, so an empty queue means the block is idle.
  task automatic wait_idle();
    while (setups_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_SRC_CLK:  src_hz_cfg = value[CLK_W-1:0];
      CFG_MIN_TONE: min_tone_cfg = value[TONE_W-1:0];
      CFG_MAX_TONE: max_tone_cfg = value[TONE_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_config(input logic [CLK_W-1:0] src, input logic [TONE_W-1:0] lo,
                            input logic [TONE_W-1:0] hi);
    wait_idle();
    write_reg(CFG_SRC_CLK, CFG_W'(src));
    write_reg(CFG_MIN_TONE, CFG_W'(lo));
    write_reg(CFG_MAX_TONE, CFG_W'(hi));
  endtask

  // Reset configuration: normal tones, clamping at both ends, mute, zero tone,
  // and the lowest tone, 20 Hz, at the minimum of the window.
  task automatic test_reset_defaults();
    send_cmd(1'b0, 16'd440);
    send_cmd(1'b1, 16'd440);
    send_cmd(1'b0, 16'd0);
    send_cmd(1'b0, 16'hFFFF);
    send_cmd(1'b0, 16'd1);
    send_cmd(1'b0, 16'd20);
    end_burst();
  endtask

  // Register extremes, divider too small, zero-frequency floor.
  task automatic test_config_extremes();
    // slowest clock with a zero window: the clamp hits 0 and is floored at 1
    set_config(28'd1, 16'd0, 16'd0);
    send_cmd(1'b0, 16'd0);
    send_cmd(1'b0, 16'hFFFF);
    send_cmd(1'b1, 16'hFFFF);
    end_burst();
    set_config(28'hFFFFFFF, 16'hFFFF, 16'hFFFF);
    send_cmd(1'b0, 16'hFFFF);
    send_cmd(1'b0, 16'd0);
    send_cmd(1'b1, 16'd0);
    end_burst();
    // a slow clock with a fast tone drives the divider below 16
    set_config(28'd1000, 16'd0, 16'hFFFF);
    send_cmd(1'b0, 16'hFFFF);
    send_cmd(1'b0, 16'd1000);
    send_cmd(1'b0, 16'd1);
    send_cmd(1'b0, 16'h5555);
    send_cmd(1'b0, 16'hAAAA);
    end_burst();
  endtask

  // Minimum above maximum: the minimum wins.
  task automatic test_clamp_order();
    set_config(28'd48000000, 16'd1000, 16'd10);
    send_cmd(1'b0, 16'd500);
    send_cmd(1'b0, 16'd5);
    send_cmd(1'b0, 16'd30000);
    end_burst();
  endtask

  // Receiver stops for a long stretch while commands keep coming, so the
  // block fills and holds off its input.
  task automatic test_backpressure();
    int i;
    set_config(SRC_CLK_RST, MIN_TONE_RST, MAX_TONE_RST);
    steady   <= 1'b1;
    hold_tok <= hold_tok + 1;
    for (i = 0; i < 12; i++) begin
      send_cmd(1'($urandom_range(1)), TONE_W'($urandom_range(3000, 20)));
    end
    steady <= 1'b0;
    end_burst();
  endtask

  // Random configuration followed by a batch of random commands.
  task automatic test_random_phase(input int n_items, input bit quiet);
    int                i;
    int                pick;
    logic [CLK_W-1:0]  src;
    logic [TONE_W-1:0] lo;
    logic [TONE_W-1:0] hi;
    logic [TONE_W-1:0] tone_hz;
    pick = $urandom_range(4);
    case (pick)
      0: src = SRC_CLK_RST;
      1: src = CLK_W'($urandom_range(5000, 1));
      2: src = CLK_W'($urandom_range(268435455, 1));
      3: src = 28'hFFFFFFF;
      default: src = CLK_W'($urandom_range(50000000, 100000));
    endcase
    lo = ($urandom_range(7) == 0) ? '0 : TONE_W'($urandom_range(100));
    hi = TONE_W'($urandom_range(65535, 1000));
    if ($urandom_range(5) == 0) begin
      // inverted window now and then
      lo = TONE_W'($urandom_range(65535));
      hi = TONE_W'($urandom_range(65535));
    end
    set_config(src, lo, hi);
    steady <= quiet;
    for (i = 0; i < n_items; i++) begin
      case ($urandom_range(3))
        0: tone_hz = TONE_W'($urandom_range(64));
        1: tone_hz = TONE_W'($urandom_range(hi > lo ? hi : lo, lo));
        default: tone_hz = TONE_W'($urandom());
      endcase
      send_cmd(($urandom_range(99) < 20), tone_hz);
    end
    steady <= 1'b0;
    end_burst();
  endtask

  // Receiver: random idle, the long hold on request, none in steady stretches.
  always @(posedge clk_i) begin
    if (hold_tok != hold_seen) begin
      hold_seen     <= hold_tok;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= steady || ($urandom_range(99) >= 7);
    end
  end

  // Result checker: a beat is taken at the next rising edge, values are stable now.
  always @(negedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (setups_due.size() == 0) begin
        report_mismatch("result with nothing pending", m_axis_tdata, 0);
      end else begin
        due = setups_due.pop_front();
        if (m_axis_tdata[DIV_W-1:0] !== due.divider)
          report_mismatch("clock_divider", m_axis_tdata[DIV_W-1:0], due.divider);
        if (m_axis_tdata[DIV_W +: WRAP_W] !== due.wrap)
          report_mismatch("wrap_value", m_axis_tdata[DIV_W +: WRAP_W], due.wrap);
        if (m_axis_tdata[LVL_LSB +: LVL_W] !== due.level)
          report_mismatch("duty_level", m_axis_tdata[LVL_LSB +: LVL_W], due.level);
        if (m_axis_tuser !== due.status)
          report_mismatch("status", m_axis_tuser, due.status);
        if (m_axis_tdata[TONE_LSB +: TONE_W] !== due.tone)
          report_mismatch("current_tone_hz", m_axis_tdata[TONE_LSB +: TONE_W], due.tone);
      end
    end
  end

  // Watchdog: too long without any beat means the block hung.
  always @(negedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int ph;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_config_extremes();
    test_clamp_order();
    test_backpressure();
    for (ph = 0; ph < 6; ph++) begin
      // phase 2 runs with no idling on either side
      test_random_phase(95, ph == 2);
    end

    while (setups_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+sv
sv/ptd_pkg.sv
sv/ptd_ctrl.sv
sv/ptd_datapath.sv
sv/pwm_tone_divider_solver.sv
test/tb.sv
